// ===== sv/critically_damped_setpoint_smoother_assert.svh =====
// assertion macros for the setpoint smoother
// no dependencies; included by modules that carry assertions
`ifndef CRITICALLY_DAMPED_SETPOINT_SMOOTHER_ASSERT_SVH
`define CRITICALLY_DAMPED_SETPOINT_SMOOTHER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CDSS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define CDSS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cdss_pkg.sv =====
// shared types, constants and saturation helpers for the setpoint smoother
// no dependencies
`default_nettype none

package cdss_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int GAIN_W        = 16;
  localparam int DT_W          = 16;
  localparam int GAIN_SHIFT    = 8;
  localparam int DT_SHIFT      = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int PROD_W        = VALUE_WIDTH + GAIN_W + 1;

  localparam int CLOSE_THR = ((1 << FRACTION_BITS) + 5) / 10;
  localparam int NEAR_W    = $clog2(CLOSE_THR) + 1;
  localparam int SQ_W      = 2 * NEAR_W;
  localparam int SUM_W     = SQ_W + 2;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [DT_W-1:0]               dt_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef val_t                          vec3_t [3];
  typedef sq_t                           sq3_t [3];

  localparam gain_t BYPASS_LIMIT = gain_t'(3);
  localparam dt_t   DT_ZERO_SUB  = dt_t'(7);

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t THR_POS = val_t'(CLOSE_THR);
  localparam val_t THR_NEG = val_t'(-CLOSE_THR);
  localparam logic [SUM_W-1:0] THR_SQ = SUM_W'(CLOSE_THR) * SUM_W'(CLOSE_THR);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFF_XY,
    REG_STIFF_Z,
    REG_DAMP_XY,
    REG_DAMP_Z
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GDIFF,
    OP_SQ,
    OP_ERR,
    OP_MULP,
    OP_MULD,
    OP_ACC,
    OP_MULDV,
    OP_VEL,
    OP_MULDS,
    OP_POS,
    OP_INIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SQ,
    ST_ERR,
    ST_MULP,
    ST_MULD,
    ST_ACC,
    ST_MULDV,
    ST_VEL,
    ST_MULDS,
    ST_POS,
    ST_INIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load_in;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic bypass;
  } stat_t;

  // saturating add or subtract
  function automatic val_t sat_add(val_t a, val_t b, logic sub);
    logic signed [VALUE_WIDTH:0] x;
    if (sub) begin
      x = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    end else begin
      x = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    end
    if (x[VALUE_WIDTH] != x[VALUE_WIDTH-1]) begin
      return x[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return x[VALUE_WIDTH-1:0];
  endfunction

  // saturate a shifted product to the value range
  function automatic val_t sat_prod(logic signed [PROD_W-1:0] x);
    if ((&x[PROD_W-1:VALUE_WIDTH-1]) || !(|x[PROD_W-1:VALUE_WIDTH-1])) begin
      return x[VALUE_WIDTH-1:0];
    end
    return x[PROD_W-1] ? VAL_MIN : VAL_MAX;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdss_lane.sv =====
// one axis of the smoother: state, error terms and a shared multiplier
// depends on cdss_pkg
`default_nettype none

module cdss_lane (
  input  logic           clk,
  input  logic           rst_n,
  input  cdss_pkg::cmd_t cmd,
  input  cdss_pkg::val_t des,
  input  cdss_pkg::val_t goal,
  input  cdss_pkg::val_t mv,
  input  cdss_pkg::gain_t kp,
  input  cdss_pkg::gain_t kd,
  input  cdss_pkg::dt_t  dt,
  input  logic           vt_zero,
  output logic           near,
  output cdss_pkg::sq_t  sq,
  output cdss_pkg::val_t pos,
  output cdss_pkg::val_t vel
);
  import cdss_pkg::*;

  val_t s_r, s_nxt;
  val_t v_r, v_nxt;
  val_t gd_r, pe_r, ve_r, p_r, d_r, acc_r, t_r;
  sq_t  sq_r;
  logic near_r;

  val_t  mul_a;
  gain_t mul_b;
  logic  mul_long;
  logic signed [PROD_W-1:0] prod, prod_sh;
  val_t  mres;
  val_t  vt;
  logic signed [NEAR_W-1:0] gd_n;

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = pe_r;
    mul_b    = kp;
    mul_long = 1'b0;
    case (cmd.op)
      OP_MULP: begin
        mul_a = pe_r;
        mul_b = kp;
      end
      OP_MULD: begin
        mul_a = ve_r;
        mul_b = kd;
      end
      OP_MULDV: begin
        mul_a    = acc_r;
        mul_b    = gain_t'(dt);
        mul_long = 1'b1;
      end
      OP_MULDS: begin
        mul_a    = v_r;
        mul_b    = gain_t'(dt);
        mul_long = 1'b1;
      end
      default: begin
        mul_a    = pe_r;
        mul_b    = kp;
        mul_long = 1'b0;
      end
    endcase
  end

  assign prod    = mul_a * $signed({1'b0, mul_b});
  assign prod_sh = mul_long ? (prod >>> DT_SHIFT) : (prod >>> GAIN_SHIFT);
  assign mres    = sat_prod(prod_sh);
  assign vt      = vt_zero ? '0 : mv;
  assign gd_n    = gd_r[NEAR_W-1:0];

  always_comb begin
    s_nxt = s_r;
    v_nxt = v_r;
    case (cmd.op)
      OP_VEL:  v_nxt = sat_add(v_r, t_r, 1'b0);
      OP_POS:  s_nxt = sat_add(s_r, t_r, 1'b0);
      OP_INIT: begin
        s_nxt = des;
        v_nxt = '0;
      end
      default: begin
        s_nxt = s_r;
        v_nxt = v_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      v_r <= '0;
    end else begin
      s_r <= s_nxt;
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_GDIFF: gd_r <= sat_add(des, goal, 1'b1);
      OP_SQ: begin
        near_r <= (gd_r > THR_NEG) && (gd_r < THR_POS);
        sq_r   <= sq_t'(gd_n * gd_n);
      end
      OP_ERR: begin
        pe_r <= sat_add(des, s_r, 1'b1);
        ve_r <= sat_add(vt, v_r, 1'b1);
      end
      OP_MULP:  p_r   <= mres;
      OP_MULD:  d_r   <= mres;
      OP_ACC:   acc_r <= sat_add(p_r, d_r, 1'b0);
      OP_MULDV: t_r   <= mres;
      OP_MULDS: t_r   <= mres;
      default: ;
    endcase
  end

  assign near = near_r;
  assign sq   = sq_r;
  assign pos  = s_r;
  assign vel  = v_r;

endmodule

`default_nettype wire

// ===== sv/cdss_datapath.sv =====
// input capture, closeness test, three axis lanes and the output register
// depends on cdss_pkg and cdss_lane
`default_nettype none

module cdss_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  cdss_pkg::cmd_t  cmd,
  input  logic            in_func,
  input  cdss_pkg::vec3_t in_des,
  input  cdss_pkg::vec3_t in_goal,
  input  cdss_pkg::vec3_t in_mv,
  input  cdss_pkg::dt_t   in_dt,
  input  cdss_pkg::gain_t kp_xy,
  input  cdss_pkg::gain_t kp_z,
  input  cdss_pkg::gain_t kd_xy,
  input  cdss_pkg::gain_t kd_z,
  output cdss_pkg::stat_t stat,
  output cdss_pkg::vec3_t out_pos,
  output cdss_pkg::vec3_t out_vel,
  output logic            out_byp
);
  import cdss_pkg::*;

  logic  func_r;
  val_t  des_r [3];
  val_t  goal_r [3];
  val_t  mv_r [3];
  dt_t   dt_r;
  val_t  pos_r [3];
  val_t  vel_r [3];
  logic  byp_r;

  logic  near [3];
  sq_t   sq [3];
  val_t  lpos [3];
  val_t  lvel [3];
  logic [SUM_W-1:0] sumsq;
  logic  close;
  logic  bypass;

  assign bypass = !func_r && ((kp_xy < BYPASS_LIMIT) || (kp_z < BYPASS_LIMIT));
  assign sumsq  = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  assign close  = near[0] && near[1] && near[2] && (sumsq < THR_SQ);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      dt_r   <= (in_dt == '0) ? DT_ZERO_SUB : in_dt;
      for (int i = 0; i < 3; i++) begin
        des_r[i]  <= in_des[i];
        goal_r[i] <= in_goal[i];
        mv_r[i]   <= in_mv[i];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    cdss_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .des     (des_r[g]),
      .goal    (goal_r[g]),
      .mv      (mv_r[g]),
      .kp      ((g < 2) ? kp_xy : kp_z),
      .kd      ((g < 2) ? kd_xy : kd_z),
      .dt      (dt_r),
      .vt_zero (close),
      .near    (near[g]),
      .sq      (sq[g]),
      .pos     (lpos[g]),
      .vel     (lvel[g])
    );
  end

  // bypass passes the desired point with the held velocity
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      byp_r <= bypass;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= bypass ? des_r[i] : lpos[i];
        vel_r[i] <= lvel[i];
      end
    end
  end

  assign stat.func   = func_r;
  assign stat.bypass = bypass;
  assign out_pos     = pos_r;
  assign out_vel     = vel_r;
  assign out_byp     = byp_r;

endmodule

`default_nettype wire

// ===== sv/cdss_ctrl.sv =====
// sequencer for the smoother: step order, handshakes and output valid
// depends on cdss_pkg and the assertion macro header
`default_nettype none
`include "critically_damped_setpoint_smoother_assert.svh"

module cdss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cdss_pkg::stat_t stat,
  output cdss_pkg::cmd_t  cmd
);
  import cdss_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.func) begin
          state_nxt = ST_INIT;
        end else if (stat.bypass) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:     state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_MULP;
      ST_MULP:   state_nxt = ST_MULD;
      ST_MULD:   state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_MULDV;
      ST_MULDV:  state_nxt = ST_VEL;
      ST_VEL:    state_nxt = ST_MULDS;
      ST_MULDS:  state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_OUT;
      ST_INIT:   state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE:   cmd.load_in = in_valid;
      ST_DECIDE: cmd.op = OP_GDIFF;
      ST_SQ:     cmd.op = OP_SQ;
      ST_ERR:    cmd.op = OP_ERR;
      ST_MULP:   cmd.op = OP_MULP;
      ST_MULD:   cmd.op = OP_MULD;
      ST_ACC:    cmd.op = OP_ACC;
      ST_MULDV:  cmd.op = OP_MULDV;
      ST_VEL:    cmd.op = OP_VEL;
      ST_MULDS:  cmd.op = OP_MULDS;
      ST_POS:    cmd.op = OP_POS;
      ST_INIT:   cmd.op = OP_INIT;
      ST_OUT:    cmd.load_out = !out_valid_r || out_ready;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `CDSS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready,
    "accepted word did not make the block busy")
  `CDSS_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || out_ready,
    "pending result word overwritten")
  `CDSS_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid,
    "loaded result word not presented")
  `CDSS_ASSERT_NOW(a_one_item, clk, rst_n, cmd.op != OP_NONE, !in_ready && !cmd.load_out,
    "step issued while idle or delivering")

endmodule

`default_nettype wire

// ===== sv/critically_damped_setpoint_smoother.sv =====
// top level of the three-axis critically damped setpoint smoother
// depends on cdss_pkg, cdss_ctrl and cdss_datapath

// Three-axis second-order setpoint smoother in Q16.16. Each axis keeps a
// smoothed position and velocity; a smoothing step (func 0) computes
// v += (Kp*(desired-s) + Kd*(vt-v))*dt and s += v*dt with saturation at every
// stage, where vt is zero when the desired point is within 0.1 m of the goal
// and the measured velocity otherwise. func 1 loads the position and clears
// the velocity. On a func 0 word, a stiffness register below 3 passes the
// desired point through with bypassed set. A step_time of zero is taken as 7.
// A smoothing word steps through decide, the closeness test, the error terms,
// the Kp and Kd multiplies, accumulate, a dt multiply, velocity, a dt multiply
// and position to the output state; a reinitialise steps through decide and
// init, and a bypassed word through decide alone. The output state waits
// while the previous result word is pending and not taken. The axes run side
// by side, each through a single shared 32x17 multiplier, one step per cycle.
// The result sits in an output register, so a new word is taken while the
// last result is pending.
// Configuration writes are accepted every cycle and must only be made while
// the block is idle.
`default_nettype none

module critically_damped_setpoint_smoother (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  cdss_pkg::gain_t                   cfg_data,
  // input word channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  cdss_pkg::val_t                    in_desired_x,
  input  cdss_pkg::val_t                    in_desired_y,
  input  cdss_pkg::val_t                    in_desired_z,
  input  cdss_pkg::val_t                    in_goal_x,
  input  cdss_pkg::val_t                    in_goal_y,
  input  cdss_pkg::val_t                    in_goal_z,
  input  cdss_pkg::val_t                    in_meas_vel_x,
  input  cdss_pkg::val_t                    in_meas_vel_y,
  input  cdss_pkg::val_t                    in_meas_vel_z,
  input  cdss_pkg::dt_t                     in_step_time,
  // result word channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output cdss_pkg::val_t                    out_smooth_x,
  output cdss_pkg::val_t                    out_smooth_y,
  output cdss_pkg::val_t                    out_smooth_z,
  output cdss_pkg::val_t                    out_smooth_vel_x,
  output cdss_pkg::val_t                    out_smooth_vel_y,
  output cdss_pkg::val_t                    out_smooth_vel_z,
  output logic                              out_bypassed
);
  import cdss_pkg::*;

  // gain registers, all reset to zero so the block starts in bypass
  gain_t kp_xy_r, kp_xy_nxt;
  gain_t kp_z_r,  kp_z_nxt;
  gain_t kd_xy_r, kd_xy_nxt;
  gain_t kd_z_r,  kd_z_nxt;

  cmd_t  cmd;
  stat_t stat;
  vec3_t in_des, in_goal, in_mv;
  vec3_t out_pos, out_vel;

  assign cfg_ready = 1'b1;

  always_comb begin
    kp_xy_nxt = kp_xy_r;
    kp_z_nxt  = kp_z_r;
    kd_xy_nxt = kd_xy_r;
    kd_z_nxt  = kd_z_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_STIFF_XY: kp_xy_nxt = cfg_data;
        REG_STIFF_Z:  kp_z_nxt  = cfg_data;
        REG_DAMP_XY:  kd_xy_nxt = cfg_data;
        REG_DAMP_Z:   kd_z_nxt  = cfg_data;
        default:      kp_xy_nxt = kp_xy_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_xy_r <= '0;
      kp_z_r  <= '0;
      kd_xy_r <= '0;
      kd_z_r  <= '0;
    end else begin
      kp_xy_r <= kp_xy_nxt;
      kp_z_r  <= kp_z_nxt;
      kd_xy_r <= kd_xy_nxt;
      kd_z_r  <= kd_z_nxt;
    end
  end

  // gather the axis fields into per-axis vectors
  assign in_des  = '{in_desired_x, in_desired_y, in_desired_z};
  assign in_goal = '{in_goal_x, in_goal_y, in_goal_z};
  assign in_mv   = '{in_meas_vel_x, in_meas_vel_y, in_meas_vel_z};

  cdss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdss_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_func (in_func),
    .in_des  (in_des),
    .in_goal (in_goal),
    .in_mv   (in_mv),
    .in_dt   (in_step_time),
    .kp_xy   (kp_xy_r),
    .kp_z    (kp_z_r),
    .kd_xy   (kd_xy_r),
    .kd_z    (kd_z_r),
    .stat    (stat),
    .out_pos (out_pos),
    .out_vel (out_vel),
    .out_byp (out_bypassed)
  );

  assign out_smooth_x     = out_pos[0];
  assign out_smooth_y     = out_pos[1];
  assign out_smooth_z     = out_pos[2];
  assign out_smooth_vel_x = out_vel[0];
  assign out_smooth_vel_y = out_vel[1];
  assign out_smooth_vel_z = out_vel[2];

endmodule

`default_nettype wire
